// File: rtl/casc_pkg.sv
`timescale 1ns / 1ps

package casc_pkg;

	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;

	localparam logic [CfgIdxW-1:0] REG_DEBOUNCE   = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_SHORT      = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_LONG       = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_MENU_LOW   = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_MENU_HIGH  = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_DIRECTION  = 3'd5;

	localparam logic [2:0] MODE_RUN   = 3'd0;
	localparam logic [2:0] MODE_MENU  = 3'd1;
	localparam logic [2:0] MODE_DATE  = 3'd2;
	localparam logic [2:0] MODE_TIME  = 3'd3;
	localparam logic [2:0] MODE_ALARM = 3'd4;

	localparam logic [2:0] CMD_NONE        = 3'd0;
	localparam logic [2:0] CMD_SAVE_DATE   = 3'd1;
	localparam logic [2:0] CMD_SAVE_TIME   = 3'd2;
	localparam logic [2:0] CMD_SET_ALARM   = 3'd3;
	localparam logic [2:0] CMD_CLEAR_ALARM = 3'd4;

	localparam logic [1:0] PICK_DATE  = 2'd0;
	localparam logic [1:0] PICK_TIME  = 2'd1;
	localparam logic [1:0] PICK_ALARM = 2'd2;

	localparam logic [15:0] DEBOUNCE_RST  = 16'd200;
	localparam logic [15:0] SHORT_RST     = 16'd2000;
	localparam logic [15:0] LONG_RST      = 16'd4000;
	localparam logic [9:0]  MENU_LOW_RST  = 10'd341;
	localparam logic [9:0]  MENU_HIGH_RST = 10'd683;
	localparam logic [9:0]  DIR_RST       = 10'd512;

	localparam logic [6:0] DAY_LO    = 7'd1;
	localparam logic [6:0] DAY_HI    = 7'd31;
	localparam logic [6:0] MONTH_LO  = 7'd1;
	localparam logic [6:0] MONTH_HI  = 7'd12;
	localparam logic [6:0] MINUTE_LO = 7'd0;
	localparam logic [6:0] MINUTE_HI = 7'd59;
	localparam logic [6:0] HOUR_LO   = 7'd0;
	localparam logic [6:0] HOUR_HI   = 7'd23;

	typedef struct packed {
		logic [15:0] debounce_ms;
		logic [15:0] short_press_ms;
		logic [15:0] long_press_ms;
		logic [9:0]  menu_low_threshold;
		logic [9:0]  menu_high_threshold;
		logic [9:0]  direction_threshold;
	} cfg_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        black_pressed;
		logic        yellow_pressed;
		logic [9:0]  knob_value;
		logic [15:0] clock_year;
		logic [3:0]  clock_month;
		logic [4:0]  clock_day;
		logic [4:0]  clock_hour;
		logic [5:0]  clock_minute;
	} item_t;

	typedef struct packed {
		logic [2:0]  mode_now;
		logic [1:0]  choice;
		logic [15:0] edit_year;
		logic [3:0]  edit_month;
		logic [4:0]  edit_day;
		logic [4:0]  edit_hour;
		logic [5:0]  edit_minute;
		logic [4:0]  alarm_hour;
		logic [5:0]  alarm_minute;
		logic [2:0]  command;
	} res_t;

	function automatic logic [6:0] step_wrap(input logic [6:0] v, input logic up,
			input logic [6:0] lo, input logic [6:0] hi);
		logic [7:0] x;
		logic       under;
		begin
			x = up ? ({1'b0, v} + 8'd1) : ({1'b0, v} - 8'd1);
			under = up ? (x < {1'b0, lo}) : (v <= lo);
			if (under) begin
				step_wrap = hi;
			end else if (x > {1'b0, hi}) begin
				step_wrap = lo;
			end else begin
				step_wrap = x[6:0];
			end
		end
	endfunction

endpackage

// File: rtl/casc_cfg.sv
`timescale 1ns / 1ps

module casc_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [casc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [casc_pkg::CfgDataW-1:0] cfg_data,
	output casc_pkg::cfg_t                cfg
);
	import casc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms         <= DEBOUNCE_RST;
			cfg_q.short_press_ms      <= SHORT_RST;
			cfg_q.long_press_ms       <= LONG_RST;
			cfg_q.menu_low_threshold  <= MENU_LOW_RST;
			cfg_q.menu_high_threshold <= MENU_HIGH_RST;
			cfg_q.direction_threshold <= DIR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEBOUNCE:  cfg_q.debounce_ms         <= cfg_data;
				REG_SHORT:     cfg_q.short_press_ms      <= cfg_data;
				REG_LONG:      cfg_q.long_press_ms       <= cfg_data;
				REG_MENU_LOW:  cfg_q.menu_low_threshold  <= cfg_data[9:0];
				REG_MENU_HIGH: cfg_q.menu_high_threshold <= cfg_data[9:0];
				REG_DIRECTION: cfg_q.direction_threshold <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/casc_core.sv
`timescale 1ns / 1ps

module casc_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  casc_pkg::item_t item,
	input  casc_pkg::cfg_t  cfg,
	output casc_pkg::res_t  res
);
	import casc_pkg::*;

	logic [2:0]  mode_q, n_mode;
	logic        bprev_q, n_bprev;
	logic        yprev_q, n_yprev;
	logic [31:0] last_q, n_last;
	logic [31:0] ystart_q, n_ystart;
	logic [15:0] year_q, n_year;
	logic [3:0]  month_q, n_month;
	logic [4:0]  day_q, n_day;
	logic [4:0]  hour_q, n_hour;
	logic [5:0]  minute_q, n_minute;
	logic [4:0]  ahour_q, n_ahour;
	logic [5:0]  amin_q, n_amin;

	logic        up, press;
	logic [31:0] gap, held;
	logic [1:0]  pick;
	logic [2:0]  cmd;
	logic [6:0]  day_step, month_step, minute_step, hour_step, amin_step, ahour_step;

	assign up    = item.knob_value > cfg.direction_threshold;
	assign gap   = item.now_ms - last_q;
	assign held  = item.now_ms - ystart_q;
	assign press = item.black_pressed && !bprev_q && (gap > {16'd0, cfg.debounce_ms});
	assign pick  = (item.knob_value < cfg.menu_low_threshold)  ? PICK_DATE :
	               (item.knob_value < cfg.menu_high_threshold) ? PICK_TIME : PICK_ALARM;

	assign day_step    = step_wrap({2'd0, day_q}, up, DAY_LO, DAY_HI);
	assign month_step  = step_wrap({3'd0, month_q}, up, MONTH_LO, MONTH_HI);
	assign minute_step = step_wrap({1'd0, minute_q}, up, MINUTE_LO, MINUTE_HI);
	assign hour_step   = step_wrap({2'd0, hour_q}, up, HOUR_LO, HOUR_HI);
	assign amin_step   = step_wrap({1'd0, amin_q}, 1'b1, MINUTE_LO, MINUTE_HI);
	assign ahour_step  = step_wrap({2'd0, ahour_q}, 1'b1, HOUR_LO, HOUR_HI);

	always_comb begin
		n_mode   = mode_q;
		n_bprev  = item.black_pressed;
		n_yprev  = yprev_q;
		n_last   = last_q;
		n_ystart = ystart_q;
		n_year   = year_q;
		n_month  = month_q;
		n_day    = day_q;
		n_hour   = hour_q;
		n_minute = minute_q;
		n_ahour  = ahour_q;
		n_amin   = amin_q;
		cmd      = CMD_NONE;
		case (mode_q) inside
			MODE_DATE, MODE_TIME, MODE_ALARM: begin
				if (item.yellow_pressed && !yprev_q) begin
					n_ystart = item.now_ms;
				end
				if (!item.yellow_pressed && yprev_q) begin
					if (mode_q == MODE_DATE) begin
						if (held < {16'd0, cfg.short_press_ms}) begin
							n_day = day_step[4:0];
						end else if (held < {16'd0, cfg.long_press_ms}) begin
							n_month = month_step[3:0];
						end else begin
							n_year = up ? (year_q + 16'd1) : (year_q - 16'd1);
						end
					end else if (mode_q == MODE_TIME) begin
						if (held < {16'd0, cfg.short_press_ms}) begin
							n_minute = minute_step[5:0];
						end else begin
							n_hour = hour_step[4:0];
						end
					end else begin
						if (held < {16'd0, cfg.short_press_ms}) begin
							n_amin = amin_step[5:0];
						end else begin
							n_ahour = ahour_step[4:0];
						end
					end
				end
				n_yprev = item.yellow_pressed;
				if (press) begin
					cmd    = (mode_q == MODE_DATE) ? CMD_SAVE_DATE :
					         (mode_q == MODE_TIME) ? CMD_SAVE_TIME :
					         (up ? CMD_SET_ALARM : CMD_CLEAR_ALARM);
					n_last = item.now_ms;
					n_mode = MODE_RUN;
				end
			end
			MODE_MENU: begin
				if (press) begin
					case (pick)
						PICK_DATE: begin
							n_year  = item.clock_year;
							n_month = item.clock_month;
							n_day   = item.clock_day;
							n_mode  = MODE_DATE;
						end
						PICK_TIME: begin
							n_hour   = item.clock_hour;
							n_minute = item.clock_minute;
							n_mode   = MODE_TIME;
						end
						default: begin
							n_ahour = item.clock_hour;
							n_amin  = item.clock_minute;
							n_mode  = MODE_ALARM;
						end
					endcase
					n_last = item.now_ms;
				end
			end
			default: begin
				if (press) begin
					n_mode = MODE_MENU;
					n_last = item.now_ms;
				end
			end
		endcase
	end

	always_comb begin
		res.mode_now     = n_mode;
		res.choice       = 2'd0;
		if (n_mode == MODE_MENU) begin
			res.choice = pick;
		end else if (n_mode == MODE_DATE || n_mode == MODE_TIME || n_mode == MODE_ALARM) begin
			res.choice = {1'b0, up};
		end
		res.edit_year    = n_year;
		res.edit_month   = n_month;
		res.edit_day     = n_day;
		res.edit_hour    = n_hour;
		res.edit_minute  = n_minute;
		res.alarm_hour   = n_ahour;
		res.alarm_minute = n_amin;
		res.command      = cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_RUN;
			bprev_q  <= 1'b0;
			yprev_q  <= 1'b0;
			last_q   <= 32'd0;
			ystart_q <= 32'd0;
			year_q   <= 16'd0;
			month_q  <= 4'd0;
			day_q    <= 5'd0;
			hour_q   <= 5'd0;
			minute_q <= 6'd0;
			ahour_q  <= 5'd0;
			amin_q   <= 6'd0;
		end else if (adv) begin
			mode_q   <= n_mode;
			bprev_q  <= n_bprev;
			yprev_q  <= n_yprev;
			last_q   <= n_last;
			ystart_q <= n_ystart;
			year_q   <= n_year;
			month_q  <= n_month;
			day_q    <= n_day;
			hour_q   <= n_hour;
			minute_q <= n_minute;
			ahour_q  <= n_ahour;
			amin_q   <= n_amin;
		end
	end

endmodule

// File: rtl/clock_alarm_setting_controller.sv
`timescale 1ns / 1ps

// A tick is held in the input register; the core's result for it goes into the result register.
// Throughput: one tick per clock cycle; a stalled result holds the result register, and the
// input register takes one more tick before in_ready drops.
// Reset (arst_n low, asynchronous): run mode, edit values zero, buttons released,
// configuration back to its default values, both stages empty.

module clock_alarm_setting_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [casc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [casc_pkg::CfgDataW-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [31:0]                   now_ms,
	input  logic                          black_pressed,
	input  logic                          yellow_pressed,
	input  logic [9:0]                    knob_value,
	input  logic [15:0]                   clock_year,
	input  logic [3:0]                    clock_month,
	input  logic [4:0]                    clock_day,
	input  logic [4:0]                    clock_hour,
	input  logic [5:0]                    clock_minute,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    mode_now,
	output logic [1:0]                    choice,
	output logic [15:0]                   edit_year,
	output logic [3:0]                    edit_month,
	output logic [4:0]                    edit_day,
	output logic [4:0]                    edit_hour,
	output logic [5:0]                    edit_minute,
	output logic [4:0]                    alarm_hour,
	output logic [5:0]                    alarm_minute,
	output logic [2:0]                    command
);
	import casc_pkg::*;

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	res_t  res, res_s2;
	logic  valid_s2;
	logic  adv;

	casc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{now_ms, black_pressed, yellow_pressed, knob_value, clock_year,
			             clock_month, clock_day, clock_hour, clock_minute};
		end
	end

	casc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign mode_now     = res_s2.mode_now;
	assign choice       = res_s2.choice;
	assign edit_year    = res_s2.edit_year;
	assign edit_month   = res_s2.edit_month;
	assign edit_day     = res_s2.edit_day;
	assign edit_hour    = res_s2.edit_hour;
	assign edit_minute  = res_s2.edit_minute;
	assign alarm_hour   = res_s2.alarm_hour;
	assign alarm_minute = res_s2.alarm_minute;
	assign command      = res_s2.command;

	a_cmd_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && command != CMD_NONE |-> mode_now == MODE_RUN)
		else $error("command issued outside run mode");

	a_run_choice: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_now == MODE_RUN |-> choice == 2'd0)
		else $error("choice nonzero in run mode");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(item_s1))
		else $error("input stage lost a stalled tick");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("input stalled with empty result stage");

endmodule
